// ----- sv/ggc_pkg.sv -----
// ----------------------------------------------------------------------------
// ggc_pkg
// shared types and constants for the greedy graph colorer
// ----------------------------------------------------------------------------
package ggc_pkg;

  localparam int unsigned NumVertices = 64;
  localparam int unsigned VW = 6;
  localparam int unsigned CW = 6;
  localparam int unsigned NumColors = 64;
  localparam int unsigned CntW = $clog2(NumVertices + 1);

  typedef enum logic [2:0] {
    CMD_ADD_EDGE = 3'd0,
    CMD_PRESET   = 3'd1,
    CMD_PENDING  = 3'd2,
    CMD_COLOR    = 3'd3,
    CMD_READ     = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WA,
    ST_EDGE_WB,
    ST_RANK,
    ST_RANK_LAST,
    ST_ROW_RD,
    ST_COL_SCAN,
    ST_COL_LAST,
    ST_WRITE,
    ST_OUT
  } state_e;

endpackage

// ----- sv/ggc_if.sv -----
// ----------------------------------------------------------------------------
// ggc_cmd_if / ggc_rsp_if
// valid/ready channels carrying command and response transactions
// ----------------------------------------------------------------------------
interface ggc_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [5:0] vertex_a;
  logic [5:0] vertex_b;
  logic [5:0] color_in;
  modport source (output valid, cmd, vertex_a, vertex_b, color_in, input ready);
  modport sink   (input valid, cmd, vertex_a, vertex_b, color_in, output ready);
endinterface

interface ggc_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] vertex_out;
  logic [5:0] color_out;
  logic       color_known;
  logic       status;
  modport source (output valid, vertex_out, color_out, color_known, status, input ready);
  modport sink   (input valid, vertex_out, color_out, color_known, status, output ready);
endinterface

// ----- sv/ggc_adj_ram.sv -----
// ----------------------------------------------------------------------------
// ggc_adj_ram
// adjacency row memory, one write and one registered read port
// ----------------------------------------------------------------------------
module ggc_adj_ram
  import ggc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [VW-1:0]          waddr_i,
  input  logic [NumVertices-1:0] wdata_i,
  input  logic [VW-1:0]          raddr_i,
  output logic [NumVertices-1:0] rdata_o
);

  logic [NumVertices-1:0] mem [NumVertices];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- sv/ggc_color_ram.sv -----
// ----------------------------------------------------------------------------
// ggc_color_ram
// per-vertex color memory, one write and one registered read port
// ----------------------------------------------------------------------------
module ggc_color_ram
  import ggc_pkg::*;
(
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [VW-1:0] waddr_i,
  input  logic [CW-1:0] wdata_i,
  input  logic [VW-1:0] raddr_i,
  output logic [CW-1:0] rdata_o
);

  logic [CW-1:0] mem [NumVertices];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- sv/greedy_graph_colorer.sv -----
// ----------------------------------------------------------------------------
// greedy_graph_colorer
// first-fit graph colorer over an adjacency memory and a color memory
// ----------------------------------------------------------------------------
// channel  dir  fields
// cmd      in   cmd, vertex_a, vertex_b, color_in
// rsp      out  vertex_out, color_out, color_known, status
//
// add edge reads and rewrites both rows; color next ranks the pending
// vertices with one adjacency row read per cycle, then one color read per
// vertex slot. the adjacency memory has no reset: rows are cleared by a
// sweep after reset, no command accepted meanwhile. the response
// register holds while rsp.ready is low; a new command waits for it.
// ----------------------------------------------------------------------------
module greedy_graph_colorer
  import ggc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ggc_cmd_if.sink   cmd_i,
  ggc_rsp_if.source rsp_o
);

  state_e state_q, state_d;

  logic [VW-1:0] a_q, b_q, best_q, idx_q;
  logic [CW-1:0] cin_q;
  logic [CntW-1:0] best_n_q;
  logic          found_q;
  logic [NumVertices-1:0] row_q;
  logic [NumColors-1:0]   used_q;
  logic [NumVertices-1:0] assigned_q, here_q, pend_q;
  logic          clr_q;
  logic [VW:0]   clr_cnt_q;

  logic [NumVertices-1:0] adj_rd, adj_wd;
  logic [VW-1:0]          adj_wa, adj_ra;
  logic                   adj_we;
  logic [CW-1:0]          col_rd, col_wd;
  logic [VW-1:0]          col_wa, col_ra;
  logic                   col_we;

  logic rv_q;
  logic [VW-1:0] rv_vtx_q;
  logic [CW-1:0] rv_col_q;
  logic rv_known_q, rv_stat_q;

  logic [VW-1:0] idx_d1_q;
  logic          scan_v_q;

  ggc_adj_ram u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(adj_wd),
    .raddr_i(adj_ra), .rdata_o(adj_rd)
  );

  ggc_color_ram u_col (
    .clk_i, .we_i(col_we), .waddr_i(col_wa), .wdata_i(col_wd),
    .raddr_i(col_ra), .rdata_o(col_rd)
  );

  logic accept;
  assign cmd_i.ready = (state_q == ST_IDLE) && !clr_q && !rv_q;
  assign accept = cmd_i.valid && cmd_i.ready;

  // popcount of the ranked row, masked to vertices colored by this block
  logic [CntW-1:0] nb_cnt;
  always_comb begin
    nb_cnt = '0;
    for (int i = 0; i < NumVertices; i++) begin
      nb_cnt = nb_cnt + CntW'(adj_rd[i] & here_q[i]);
    end
  end

  logic [CW-1:0] free_col;
  logic          free_hit;
  always_comb begin
    free_col = CW'(NumColors - 1);
    free_hit = 1'b0;
    for (int c = 0; c < NumColors; c++) begin
      if (!used_q[c] && !free_hit) begin
        free_col = CW'(c);
        free_hit = 1'b1;
      end
    end
  end

  logic idx_last;
  assign idx_last = (idx_q == VW'(NumVertices - 1));

  // whether the last ranked vertex takes over the best slot
  logic last_wins;
  assign last_wins = pend_q[idx_d1_q] && (!found_q || nb_cnt > best_n_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i.cmd)
            CMD_ADD_EDGE: state_d = ST_EDGE_RD;
            CMD_COLOR:    state_d = ST_RANK;
            default:      state_d = ST_OUT;
          endcase
        end
      end
      ST_EDGE_RD:   state_d = ST_EDGE_WA;
      ST_EDGE_WA:   state_d = ST_EDGE_WB;
      ST_EDGE_WB:   state_d = ST_OUT;
      ST_RANK:      state_d = idx_last ? ST_RANK_LAST : ST_RANK;
      ST_RANK_LAST: state_d = ST_ROW_RD;
      ST_ROW_RD:    state_d = found_q ? ST_COL_SCAN : ST_OUT;
      ST_COL_SCAN:  state_d = idx_last ? ST_COL_LAST : ST_COL_SCAN;
      ST_COL_LAST:  state_d = ST_WRITE;
      ST_WRITE:     state_d = ST_OUT;
      ST_OUT:       state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    adj_we = 1'b0;
    adj_wa = a_q;
    adj_wd = adj_rd;
    adj_ra = idx_q;
    col_we = 1'b0;
    col_wa = a_q;
    col_wd = cin_q;
    col_ra = idx_q;
    if (clr_q) begin
      adj_we = 1'b1;
      adj_wa = clr_cnt_q[VW-1:0];
      adj_wd = '0;
    end
    case (state_q)
      ST_IDLE: begin
        adj_ra = cmd_i.vertex_a;
        col_ra = cmd_i.vertex_a;
        if (accept && cmd_i.cmd == CMD_PRESET) begin
          col_we = 1'b1;
          col_wa = cmd_i.vertex_a;
          col_wd = cmd_i.color_in;
        end
      end
      ST_EDGE_RD: adj_ra = a_q;
      ST_EDGE_WA: begin
        adj_ra = b_q;
        adj_we = 1'b1;
        adj_wa = a_q;
        adj_wd = adj_rd | (NumVertices'(1) << b_q);
      end
      ST_EDGE_WB: begin
        adj_we = 1'b1;
        adj_wa = b_q;
        adj_wd = adj_rd | (NumVertices'(1) << a_q);
      end
      ST_RANK_LAST: adj_ra = last_wins ? idx_d1_q : best_q;
      ST_ROW_RD:    col_ra = '0;
      ST_WRITE: begin
        col_we = 1'b1;
        col_wa = best_q;
        col_wd = free_col;
      end
      ST_OUT: col_ra = rv_vtx_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
      assigned_q <= '0;
      here_q     <= '0;
      pend_q     <= '0;
      rv_q       <= 1'b0;
      found_q    <= 1'b0;
      scan_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == (VW+1)'(NumVertices - 1)) clr_q <= 1'b0;
      end
      if (rv_q && rsp_o.ready) rv_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            a_q   <= cmd_i.vertex_a;
            b_q   <= cmd_i.vertex_b;
            cin_q <= cmd_i.color_in;
            idx_q <= '0;
            found_q <= 1'b0;
            scan_v_q <= 1'b0;
            rv_vtx_q <= cmd_i.vertex_a;
            rv_stat_q <= 1'b0;
            if (cmd_i.cmd == CMD_PRESET) assigned_q[cmd_i.vertex_a] <= 1'b1;
            if (cmd_i.cmd == CMD_PENDING) pend_q[cmd_i.vertex_a] <= 1'b1;
          end
        end
        ST_RANK: begin
          idx_q <= idx_q + 1'b1;
          idx_d1_q <= idx_q;
          scan_v_q <= 1'b1;
          if (scan_v_q && pend_q[idx_d1_q] && (!found_q || nb_cnt > best_n_q)) begin
            found_q  <= 1'b1;
            best_q   <= idx_d1_q;
            best_n_q <= nb_cnt;
          end
        end
        ST_RANK_LAST: begin
          idx_q <= '0;
          if (last_wins) begin
            found_q <= 1'b1;
            best_q  <= idx_d1_q;
          end
        end
        ST_ROW_RD: begin
          row_q  <= adj_rd & assigned_q;
          used_q <= '0;
          idx_q  <= 6'd1;
          idx_d1_q <= '0;
          if (!found_q) begin
            rv_stat_q <= 1'b1;
          end
        end
        ST_COL_SCAN, ST_COL_LAST: begin
          idx_q <= idx_q + 1'b1;
          idx_d1_q <= idx_q;
          if (row_q[idx_d1_q]) used_q[col_rd] <= 1'b1;
        end
        ST_WRITE: begin
          assigned_q[best_q] <= 1'b1;
          here_q[best_q]     <= 1'b1;
          pend_q[best_q]     <= 1'b0;
          rv_vtx_q <= best_q;
        end
        ST_OUT: begin
          rv_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // response fields; the color read lands in the cycle after ST_OUT
  logic known_w;
  logic rd_lat_q;
  logic [CW-1:0] rsp_col_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_lat_q <= 1'b0;
    end else begin
      rd_lat_q <= (state_q == ST_OUT);
    end
  end
  assign known_w = !rv_stat_q && assigned_q[rv_vtx_q];
  always_ff @(posedge clk_i) begin
    if (rd_lat_q) rsp_col_q <= col_rd;
  end
  assign rv_col_q  = rd_lat_q ? col_rd : rsp_col_q;
  assign rv_known_q = known_w;

  assign rsp_o.valid       = rv_q;
  assign rsp_o.vertex_out  = rv_vtx_q;
  assign rsp_o.color_out   = rv_known_q ? rv_col_q : '0;
  assign rsp_o.color_known = rv_known_q;
  assign rsp_o.status      = rv_stat_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !cmd_i.ready) else $error("accept while busy");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !cmd_i.ready) else $error("accept during clear");
  a_out_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |=> rv_q) else $error("missing response");
  a_write_clears_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> !pend_q[$past(best_q)]) else $error("pending kept");

endmodule

// ----- tb/greedy_graph_colorer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_graph_colorer_tb
// drives command transactions into the graph colorer and checks every
// response against an in-bench model of the adjacency, color and mark state.
// covers directed corner cases, color exhaustion, random graph building and
// coloring, long response back-pressure and a run with no idling.
// ----------------------------------------------------------------------------
module greedy_graph_colorer_tb;
  import ggc_pkg::*;

  localparam logic [2:0] CMD_UNDEF_5 = 3'd5;
  localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
  localparam logic [2:0] CMD_UNDEF_7 = 3'd7;
  localparam int unsigned CycleLimit = 1_000_000;

  typedef struct packed {
    logic [5:0] vertex;
    logic [5:0] color;
    logic       known;
    logic       status;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   cycles = 0;
  bit   idle_en = 1'b1;
  int   hold_req = 0;
  int   hold_cnt = 0;
  int   stall_cnt = 0;

  bit [63:0] adj_rows [64];
  bit [5:0]  vtx_color [64];
  bit [63:0] assigned_m, here_m, pend_m;
  reply_t    replies_q [$];

  ggc_cmd_if cmd_if ();
  ggc_rsp_if rsp_if ();

  greedy_graph_colorer dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t timeout", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  // response ready with random stalls and a long requested hold
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      rsp_if.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt = stall_cnt - 1;
      rsp_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_cnt = $urandom_range(0, 17);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.vertex_out, rsp_if.color_out, rsp_if.color_known, rsp_if.status};
      if (replies_q.size() == 0) begin
        $display("%0t unexpected response %p", $time, got);
        errors++;
      end else begin
        want = replies_q.pop_front();
        if (got.vertex !== want.vertex) begin
          $display("%0t vertex_out exp %0d got %0d", $time, want.vertex, got.vertex);
          errors++;
        end
        if (got.color !== want.color) begin
          $display("%0t color_out exp %0d got %0d", $time, want.color, got.color);
          errors++;
        end
        if (got.known !== want.known) begin
          $display("%0t color_known exp %0d got %0d", $time, want.known, got.known);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
      end
    end
  end

  function automatic bit [5:0] lowest_free_color(int unsigned v);
    bit [63:0] used = '0;
    bit [63:0] nb = adj_rows[v] & assigned_m;
    for (int i = 0; i < 64; i++)
      if (nb[i]) used[vtx_color[i]] = 1'b1;
    for (int c = 0; c < 64; c++)
      if (!used[c]) return 6'(c);
    return 6'd63;
  endfunction

  function automatic reply_t apply_command(logic [2:0] c, logic [5:0] a, logic [5:0] b,
                                           logic [5:0] col);
    reply_t r;
    int best = -1;
    int best_n = 0;
    int n;
    if (c == CMD_COLOR) begin
      for (int i = 0; i < 64; i++) begin
        if (pend_m[i]) begin
          n = $countones(adj_rows[i] & here_m);
          if (best < 0 || n > best_n) begin
            best = i;
            best_n = n;
          end
        end
      end
      if (best < 0) return '{a, 6'd0, 1'b0, 1'b1};
      vtx_color[best] = lowest_free_color(best);
      assigned_m[best] = 1'b1;
      here_m[best] = 1'b1;
      pend_m[best] = 1'b0;
      return '{6'(best), vtx_color[best], 1'b1, 1'b0};
    end
    case (c)
      CMD_ADD_EDGE: begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
      end
      CMD_PRESET: begin
        vtx_color[a] = col;
        assigned_m[a] = 1'b1;
      end
      CMD_PENDING: pend_m[a] = 1'b1;
      default: ;
    endcase
    r.vertex = a;
    r.known  = assigned_m[a];
    r.color  = assigned_m[a] ? vtx_color[a] : 6'd0;
    r.status = 1'b0;
    return r;
  endfunction

  task automatic send_cmd(logic [2:0] c, logic [5:0] a, logic [5:0] b = 6'd0,
                          logic [5:0] col = 6'd0);
    int gap = 0;
    reply_t exp_r;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.cmd      <= c;
    cmd_if.vertex_a <= a;
    cmd_if.vertex_b <= b;
    cmd_if.color_in <= col;
    do @(posedge clk); while (!cmd_if.ready);
    exp_r = apply_command(c, a, b, col);
    replies_q.insert(replies_q.size(), exp_r);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (replies_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_cmd(CMD_READ, 6'd0);
    send_cmd(CMD_READ, 6'd63);
    send_cmd(CMD_COLOR, 6'd17);
    send_cmd(CMD_ADD_EDGE, 6'd0, 6'd63);
    send_cmd(CMD_ADD_EDGE, 6'd5, 6'd5);
    send_cmd(CMD_ADD_EDGE, 6'd63, 6'd5);
    send_cmd(CMD_PRESET, 6'd63, 6'd0, 6'd63);
    send_cmd(CMD_PENDING, 6'd0);
    send_cmd(CMD_PENDING, 6'd5);
    send_cmd(CMD_COLOR, 6'd0);
    send_cmd(CMD_COLOR, 6'd63);
    send_cmd(CMD_COLOR, 6'd42);
    send_cmd(CMD_READ, 6'd0);
    send_cmd(CMD_PENDING, 6'd0);
    send_cmd(CMD_COLOR, 6'd1);
    send_cmd(CMD_PRESET, 6'd0, 6'd0, 6'd42);
    send_cmd(CMD_READ, 6'd0);
    send_cmd(CMD_UNDEF_5, 6'd0, 6'd63, 6'd63);
    send_cmd(CMD_UNDEF_6, 6'd63, 6'd63, 6'd63);
    send_cmd(CMD_UNDEF_7, 6'd5, 6'd0, 6'd0);
    send_cmd(CMD_PRESET, 6'd63, 6'd63, 6'd0);
    send_cmd(CMD_READ, 6'd5);
    drain();
  endtask

  task automatic test_colors_exhausted();
    for (int i = 0; i < 64; i++) send_cmd(CMD_ADD_EDGE, 6'd10, 6'(i));
    for (int i = 0; i < 64; i++) send_cmd(CMD_PRESET, 6'(i), 6'd0, 6'(i));
    send_cmd(CMD_PENDING, 6'd10);
    send_cmd(CMD_COLOR, 6'd0);
    drain();
  endtask

  task automatic test_random(int count);
    int sent = 0;
    int lo, span;
    logic [5:0] va;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_cmd(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        sent++;
      end else begin
        // build a small subgraph, maybe preset a vertex, mark it, color it, read one back
        lo = $urandom_range(0, 63);
        span = $urandom_range(2, 8);
        repeat ($urandom_range(2, 10)) begin
          send_cmd(CMD_ADD_EDGE, 6'(lo + $urandom_range(0, span)),
                   6'(lo + $urandom_range(0, span)));
          sent++;
        end
        if ($urandom_range(0, 2) == 0) begin
          send_cmd(CMD_PRESET, 6'(lo + $urandom_range(0, span)),
                   6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
          sent++;
        end
        repeat ($urandom_range(1, 5)) begin
          send_cmd(CMD_PENDING, 6'(lo + $urandom_range(0, span)));
          sent++;
        end
        repeat ($urandom_range(1, 6)) begin
          send_cmd(CMD_COLOR, 6'($urandom_range(0, 63)));
          sent++;
        end
        va = 6'(lo + $urandom_range(0, span));
        send_cmd(CMD_READ, va);
        sent++;
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 400;
    repeat (12) begin
      send_cmd(CMD_PENDING, 6'($urandom_range(0, 63)));
      send_cmd(CMD_READ, 6'($urandom_range(0, 63)));
    end
    drain();
    send_cmd(CMD_COLOR, 6'd3);
    drain();
  endtask

  initial begin
    cmd_if.valid    <= 1'b0;
    cmd_if.cmd      <= CMD_READ;
    cmd_if.vertex_a <= '0;
    cmd_if.vertex_b <= '0;
    cmd_if.color_in <= '0;
    foreach (adj_rows[i]) begin
      adj_rows[i] = '0;
      vtx_color[i] = '0;
    end
    assigned_m = '0;
    here_m = '0;
    pend_m = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(180);
    test_backpressure();
    test_colors_exhausted();
    test_random(100);
    idle_en = 1'b0;
    test_random(50);
    cmd_if.valid <= 1'b0;
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ggc_pkg.sv
sv/ggc_if.sv
sv/ggc_adj_ram.sv
sv/ggc_color_ram.sv
sv/greedy_graph_colorer.sv
tb/greedy_graph_colorer_tb.sv
